### design/rk4_pkg.sv
// Shared constants, command types and fixed-point helpers for the RK4 integrator.
package rk4_pkg;

   localparam int FracBits  = 16;
   localparam int MaxSteps  = 64;
   localparam int StepW     = 7;
   localparam int DataW     = 32;
   localparam int StepSizeW = 31;
   localparam int SumW      = 35;
   localparam int DivW      = 36;
   localparam int DivDigits = DivW / 4;
   localparam int DigitW    = $clog2(DivDigits);
   localparam int DivRecip  = 43;   // floor(t*43/256) == floor(t/6) for t < 96
   localparam int DivSix    = 6;
   localparam int RoundAdd  = 3;    // half of six, for round-half-away
   localparam int ReqDataW  = 8;
   localparam int RspDataW  = 72;
   localparam int CsrIndexW = 2;

   localparam logic signed [63:0] OneFx     = 64'sd1 <<< FracBits;
   localparam logic signed [63:0] RoundHalf = 64'sd1 <<< (FracBits - 1);
   localparam logic signed [63:0] SatMax    = 64'sd2147483647;
   localparam logic signed [63:0] SatMin    = -64'sd2147483648;

   localparam logic [CsrIndexW-1:0] CSR_START_X   = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_START_Y   = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_STEP_SIZE = 2'd2;

   localparam logic signed [DataW-1:0]  StartXReset   = 32'sd0;
   localparam logic signed [DataW-1:0]  StartYReset   = 32'sd32768;
   localparam logic [StepSizeW-1:0]     StepSizeReset = 31'd13107;

   // slope stage: k1 .. k4
   localparam logic [1:0] STAGE_K1 = 2'd0;
   localparam logic [1:0] STAGE_K2 = 2'd1;
   localparam logic [1:0] STAGE_K3 = 2'd2;
   localparam logic [1:0] STAGE_K4 = 2'd3;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SETUP,
      OP_SQ,
      OP_SQRND,
      OP_SLOPE,
      OP_KMUL,
      OP_KRND,
      OP_YARG,
      OP_DIVINIT,
      OP_DIV,
      OP_FINISH,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [1:0]       stage;
      logic [StepW-1:0] step_idx;
      logic             last;
   } cmd_type;

   function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v);
      logic signed [DataW-1:0] r;
      priority if (v > SatMax) r = 32'sh7FFF_FFFF;
      else if (v < SatMin)     r = 32'sh8000_0000;
      else                     r = v[DataW-1:0];
      return r;
   endfunction

   function automatic logic sat_hit(input logic signed [63:0] v);
      return (v > SatMax) || (v < SatMin);
   endfunction

   // round half up, floor shift
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] p);
      return (p + RoundHalf) >>> FracBits;
   endfunction

endpackage

### design/rk4_dpath.sv
// Datapath: config registers, point state, shared multiplier, saturation and divide-by-six.
module rk4_dpath import rk4_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CsrIndexW-1:0]    csr_index,
   input  logic [DataW-1:0]        csr_wdata,
   input  cmd_type                 cmd,
   output logic [StepW-1:0]        rsp_step_index,
   output logic signed [DataW-1:0] rsp_x_value,
   output logic signed [DataW-1:0] rsp_y_value,
   output logic                    rsp_overflow,
   output logic                    rsp_last_step
);

   logic signed [DataW-1:0] start_x_ff, start_x_in;
   logic signed [DataW-1:0] start_y_ff, start_y_in;
   logic [StepSizeW-1:0]    step_size_ff, step_size_in;

   logic signed [DataW-1:0] cur_x_ff, cur_x_in;
   logic signed [DataW-1:0] cur_y_ff, cur_y_in;
   logic signed [DataW-1:0] xm_ff, xm_in;
   logic signed [DataW-1:0] xe_ff, xe_in;
   logic signed [DataW-1:0] ya_ff, ya_in;
   logic signed [DataW-1:0] sq_ff, sq_in;
   logic signed [DataW-1:0] f_ff, f_in;
   logic signed [DataW-1:0] k_ff, k_in;
   logic signed [63:0]      p_ff, p_in;
   logic signed [SumW-1:0]  sum_ff, sum_in;
   logic                    ovf_ff, ovf_in;
   logic [DivW-1:0]         dvd_ff, dvd_in;
   logic [DivW-1:0]         quo_ff, quo_in;
   logic [2:0]              rem_ff, rem_in;
   logic                    neg_ff, neg_in;

   logic [StepW-1:0]        out_idx_ff, out_idx_in;
   logic signed [DataW-1:0] out_x_ff, out_x_in;
   logic signed [DataW-1:0] out_y_ff, out_y_in;
   logic                    out_ovf_ff, out_ovf_in;
   logic                    out_last_ff, out_last_in;

   logic signed [DataW-1:0] h_s, xa, mul_a, mul_b;
   logic signed [63:0]      h64, prod, rnd, xm_sum, xe_sum, slope_sum, yarg_sum;
   logic signed [63:0]      q64, qs, y_fin;
   logic signed [SumW-1:0]  k_term;
   logic [SumW-1:0]         abs_sum;
   logic [6:0]              t_div, t_rem;
   logic [11:0]             t_scaled;
   logic [3:0]              qd;

   assign h_s = signed'({1'b0, step_size_ff});
   assign h64 = 64'(h_s);

   always_comb begin
      unique case (cmd.stage)
         STAGE_K1:           xa = cur_x_ff;
         STAGE_K2, STAGE_K3: xa = xm_ff;
         STAGE_K4:           xa = xe_ff;
         default:            xa = cur_x_ff;
      endcase
   end

   // one shared 32x32 multiplier
   assign mul_a = (cmd.op == OP_KMUL) ? h_s  : xa;
   assign mul_b = (cmd.op == OP_KMUL) ? f_ff : xa;
   assign prod  = 64'(mul_a) * 64'(mul_b);

   assign rnd       = rnd_shift(p_ff);
   assign xm_sum    = 64'(cur_x_ff) + (h64 >>> 1);
   assign xe_sum    = 64'(cur_x_ff) + h64;
   assign slope_sum = 64'(ya_ff) - 64'(sq_ff) + OneFx;
   assign yarg_sum  = (cmd.stage == STAGE_K3) ? 64'(cur_y_ff) + 64'(k_ff)
                                              : 64'(cur_y_ff) + 64'(k_ff >>> 1);
   assign k_term    = (cmd.stage == STAGE_K2 || cmd.stage == STAGE_K3)
                      ? (SumW'(k_ff) <<< 1) : SumW'(k_ff);

   assign abs_sum   = sum_ff[SumW-1] ? SumW'(-sum_ff) : SumW'(sum_ff);

   // one hex digit of the quotient per cycle
   assign t_div    = {rem_ff, dvd_ff[DivW-1 -: 4]};
   assign t_scaled = 12'(t_div) * 12'(DivRecip);
   assign qd       = t_scaled[11:8];
   assign t_rem    = t_div - 7'(qd) * 7'(DivSix);

   assign q64   = 64'(quo_ff);
   assign qs    = neg_ff ? -q64 : q64;
   assign y_fin = 64'(cur_y_ff) + qs;

   always_comb begin
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      step_size_in = step_size_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_X:   start_x_in   = signed'(csr_wdata);
            CSR_START_Y:   start_y_in   = signed'(csr_wdata);
            CSR_STEP_SIZE: step_size_in = csr_wdata[StepSizeW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      xm_in       = xm_ff;
      xe_in       = xe_ff;
      ya_in       = ya_ff;
      sq_in       = sq_ff;
      f_in        = f_ff;
      k_in        = k_ff;
      p_in        = p_ff;
      sum_in      = sum_ff;
      ovf_in      = ovf_ff;
      dvd_in      = dvd_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      neg_in      = neg_ff;
      out_idx_in  = out_idx_ff;
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_ovf_in  = out_ovf_ff;
      out_last_in = out_last_ff;
      unique case (cmd.op)
         OP_NONE: ;
         OP_LOAD: begin
            cur_x_in = start_x_ff;
            cur_y_in = start_y_ff;
         end
         OP_SETUP: begin
            xm_in  = sat32(xm_sum);
            xe_in  = sat32(xe_sum);
            ya_in  = cur_y_ff;
            sum_in = '0;
            ovf_in = sat_hit(xm_sum) | sat_hit(xe_sum);
         end
         OP_SQ, OP_KMUL: p_in = prod;
         OP_SQRND: begin
            sq_in  = sat32(rnd);
            ovf_in = ovf_ff | sat_hit(rnd);
         end
         OP_SLOPE: begin
            f_in   = sat32(slope_sum);
            ovf_in = ovf_ff | sat_hit(slope_sum);
         end
         OP_KRND: begin
            k_in   = sat32(rnd);
            ovf_in = ovf_ff | sat_hit(rnd);
         end
         OP_YARG: begin
            sum_in = sum_ff + k_term;
            if (cmd.stage != STAGE_K4) begin
               ya_in  = sat32(yarg_sum);
               ovf_in = ovf_ff | sat_hit(yarg_sum);
            end
         end
         OP_DIVINIT: begin
            dvd_in = DivW'(abs_sum) + DivW'(RoundAdd);
            quo_in = '0;
            rem_in = '0;
            neg_in = sum_ff[SumW-1];
         end
         OP_DIV: begin
            dvd_in = {dvd_ff[DivW-5:0], 4'b0};
            quo_in = {quo_ff[DivW-5:0], qd};
            rem_in = t_rem[2:0];
         end
         OP_FINISH: begin
            cur_x_in = xe_ff;
            cur_y_in = sat32(y_fin);
            ovf_in   = ovf_ff | sat_hit(y_fin);
         end
         OP_EMIT: begin
            out_idx_in  = cmd.step_idx;
            out_x_in    = cur_x_ff;
            out_y_in    = cur_y_ff;
            out_ovf_in  = ovf_ff;
            out_last_in = cmd.last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff   <= StartXReset;
         start_y_ff   <= StartYReset;
         step_size_ff <= StepSizeReset;
      end else begin
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         step_size_ff <= step_size_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      xm_ff       <= xm_in;
      xe_ff       <= xe_in;
      ya_ff       <= ya_in;
      sq_ff       <= sq_in;
      f_ff        <= f_in;
      k_ff        <= k_in;
      p_ff        <= p_in;
      sum_ff      <= sum_in;
      ovf_ff      <= ovf_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      out_idx_ff  <= out_idx_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_ovf_ff  <= out_ovf_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_step_index = out_idx_ff;
   assign rsp_x_value    = out_x_ff;
   assign rsp_y_value    = out_y_ff;
   assign rsp_overflow   = out_ovf_ff;
   assign rsp_last_step  = out_last_ff;

endmodule

### design/rk4_ctrl.sv
// Controller: step sequencer, stage and digit counters, request and response handshake.
module rk4_ctrl import rk4_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [StepW-1:0] req_step_count,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output cmd_type          cmd
);

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b0000_0000_0001,
      ST_SETUP   = 12'b0000_0000_0010,
      ST_SQ      = 12'b0000_0000_0100,
      ST_SQRND   = 12'b0000_0000_1000,
      ST_SLOPE   = 12'b0000_0001_0000,
      ST_KMUL    = 12'b0000_0010_0000,
      ST_KRND    = 12'b0000_0100_0000,
      ST_YARG    = 12'b0000_1000_0000,
      ST_DIVINIT = 12'b0001_0000_0000,
      ST_DIV     = 12'b0010_0000_0000,
      ST_FINISH  = 12'b0100_0000_0000,
      ST_EMIT    = 12'b1000_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        stage_ff, stage_in;
   logic [DigitW-1:0] digit_ff, digit_in;
   logic [StepW-1:0]  step_ff, step_in;
   logic [StepW-1:0]  want_ff, want_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [StepW-1:0]  count_clamped;
   logic              accept;

   assign req_tready    = (state_ff == ST_IDLE);
   assign rsp_tvalid    = rsp_valid_ff;
   assign accept        = req_tvalid && req_tready;
   assign count_clamped = (req_step_count > StepW'(MaxSteps)) ? StepW'(MaxSteps)
                                                              : req_step_count;

   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      digit_in     = digit_ff;
      step_in      = step_ff;
      want_in      = want_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = OP_NONE;
      cmd.stage    = stage_ff;
      cmd.step_idx = step_ff;
      cmd.last     = (step_ff == want_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.op  = OP_LOAD;
               want_in = count_clamped;
               step_in = StepW'(1);
               if (count_clamped != '0) state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.op   = OP_SETUP;
            stage_in = STAGE_K1;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.op   = OP_SQ;
            state_in = ST_SQRND;
         end
         ST_SQRND: begin
            cmd.op   = OP_SQRND;
            state_in = ST_SLOPE;
         end
         ST_SLOPE: begin
            cmd.op   = OP_SLOPE;
            state_in = ST_KMUL;
         end
         ST_KMUL: begin
            cmd.op   = OP_KMUL;
            state_in = ST_KRND;
         end
         ST_KRND: begin
            cmd.op   = OP_KRND;
            state_in = ST_YARG;
         end
         ST_YARG: begin
            cmd.op = OP_YARG;
            if (stage_ff == STAGE_K4) begin
               state_in = ST_DIVINIT;
            end else begin
               stage_in = stage_ff + 2'd1;
               state_in = ST_SQ;
            end
         end
         ST_DIVINIT: begin
            cmd.op   = OP_DIVINIT;
            digit_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op   = OP_DIV;
            digit_in = digit_ff + DigitW'(1);
            if (digit_ff == DigitW'(DivDigits - 1)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.op   = OP_FINISH;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
               if (step_ff == want_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in  = step_ff + StepW'(1);
                  state_in = ST_SETUP;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stage_ff     <= STAGE_K1;
         digit_ff     <= '0;
         step_ff      <= '0;
         want_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         digit_ff     <= digit_in;
         step_ff      <= step_in;
         want_ff      <= want_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/rk4_ode_integrator.sv
// A request of n steps (clamped to 64) is served one step at a time; a request of zero steps
// gives no response, and no new request is taken until the last response has been emitted.
// Step time is set by the single shared multiplier (eight products per step, each rounded
// and saturated in its own state) and the nine-digit hex-digit divide by six.
// Reset (synchronous, active high) returns the sequencer to idle, drops rsp_tvalid and
// loads start_x = 0, start_y = 0.5, step_size = 13107; no clearing pass.
module rk4_ode_integrator import rk4_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ReqDataW-1:0]  req_tdata,   // [6:0] step_count, [7] zero
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RspDataW-1:0]  rsp_tdata,   // [6:0] step_index, [38:7] x_value,
                                             // [70:39] y_value, [71] zero
   output logic                 rsp_tuser,   // [0] overflow
   output logic                 rsp_tlast,   // last_step
   // register writes
   input  logic                 csr_we,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [DataW-1:0]     csr_wdata
);

   cmd_type                 ctrl_cmd;
   logic [StepW-1:0]        rsp_step_index;
   logic signed [DataW-1:0] rsp_x_value;
   logic signed [DataW-1:0] rsp_y_value;
   logic                    rsp_overflow;
   logic                    rsp_last_step;

   // Sequencer: one state per datapath operation; each step walks
   // SETUP, four passes of SQ/SQRND/SLOPE/KMUL/KRND/YARG, DIVINIT,
   // nine DIV digits, FINISH and EMIT.
   rk4_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_step_count (req_tdata[StepW-1:0]),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .cmd            (ctrl_cmd)
   );

   // Datapath holds the point, the slopes, the running weighted sum
   // and the output register that decouples the response side.
   rk4_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (ctrl_cmd),
      .rsp_step_index (rsp_step_index),
      .rsp_x_value    (rsp_x_value),
      .rsp_y_value    (rsp_y_value),
      .rsp_overflow   (rsp_overflow),
      .rsp_last_step  (rsp_last_step)
   );

   assign rsp_tdata = {1'b0, rsp_y_value, rsp_x_value, rsp_step_index};
   assign rsp_tuser = rsp_overflow;
   assign rsp_tlast = rsp_last_step;

   // output register is only overwritten once the held response is gone
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.op == OP_EMIT |-> (!rsp_tvalid || rsp_tready))
      else $error("response overwritten while still held");

   // a nonzero step count starts a step right away
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata[StepW-1:0] != '0) |=> ctrl_cmd.op == OP_SETUP)
      else $error("request taken but no step started");

   // the final response returns the sequencer to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (ctrl_cmd.op == OP_EMIT && ctrl_cmd.last) |=> req_tready)
      else $error("not idle after last response");

   // while idle the datapath only ever loads the start point
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (ctrl_cmd.op == OP_NONE || ctrl_cmd.op == OP_LOAD))
      else $error("datapath busy while idle");

   // step index on a response is one-based and within the clamp
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_step_index != '0 && rsp_step_index <= StepW'(MaxSteps)))
      else $error("response step index out of range");

endmodule
